>>> src/ctt_pkg.sv
`default_nettype none
package ctt_pkg;

  // Token kinds as reported on token_kind
  typedef enum logic [4:0] {
    K_NEWLINE  = 5'd0,
    K_COLON    = 5'd1,
    K_SEMI     = 5'd2,
    K_COMMA    = 5'd3,
    K_EQUAL    = 5'd4,
    K_STAR     = 5'd5,
    K_LBRACE   = 5'd6,
    K_RBRACE   = 5'd7,
    K_LBRACKET = 5'd8,
    K_RBRACKET = 5'd9,
    K_LPAREN   = 5'd10,
    K_RPAREN   = 5'd11,
    K_MINUS    = 5'd12,
    K_DOT      = 5'd13,
    K_STRING   = 5'd14,
    K_IDENT    = 5'd15,
    K_INT      = 5'd16,
    K_FLOAT    = 5'd17,
    K_UNKNOWN  = 5'd18
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_F    = 8'h66;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  // Entries of the token queue between scanner and emitter
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] length;
    logic [63:0] value;
    logic [31:0] number;
    logic        run_last;
    logic        stream_end;
  } tok_t;

  // Tokens caused by one byte: t0 always, t1 when two is set
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } pair_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
           ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
  endfunction

endpackage
`default_nettype wire

>>> src/ctt_if.sv
`default_nettype none
// Byte stream into the tokenizer
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// Token stream out of the tokenizer
interface ctt_out_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  token_kind;
  logic        [31:0] token_start;
  logic        [31:0] token_length;
  logic signed [63:0] integer_value;
  logic        [31:0] token_number;
  logic               run_last;
  logic               stream_end;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output integer_value, output token_number, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input integer_value, input token_number, input run_last,
                  input stream_end, output ready);
endinterface
`default_nettype wire

>>> src/ctt_scan.sv
`default_nettype none
module ctt_scan #(
  parameter int OFFSET_WIDTH = 32,
  parameter int VALUE_WIDTH  = 64
) (
  input  logic           clk,
  input  logic           rst,
  ctt_in_if.sink         text,
  input  logic           q_full,
  output logic           push,
  output ctt_pkg::pair_t push_data
);
  import ctt_pkg::*;

  localparam int OW = OFFSET_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam logic [VW-1:0] MAG_CAP = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] MAG_MAX = {1'b0, {(VW-1){1'b1}}};

  typedef enum logic [2:0] {
    M_IDLE,
    M_HELD,
    M_COMMENT,
    M_IDENT,
    M_NUMBER,
    M_STRING,
    M_BLOCK,
    M_BRACE
  } mode_t;

  typedef struct packed {
    mode_t         mode;
    logic [7:0]    held;
    logic [OW-1:0] start;
    logic [OW-1:0] span;
    logic [VW-1:0] acc;
    logic          neg;
    logic          stopped;
    logic          dot;
  } scan_t;

  typedef struct packed {
    logic v;
    tok_t t;
  } cand_t;

  scan_t         s, s1, s_next, fin_src;
  logic [OW-1:0] pos, pos_next;
  logic [31:0]   count, count_next;
  logic [7:0]    ch;
  logic          accept, zero_byte, ended, take_a, idle_go;
  cand_t         fin_a, cand_a, cand_b, cand_c, fin_c, slot0, slot1;

  // Saturating add of 1 or 2 to an offset
  function automatic logic [OW-1:0] sat_add(logic [OW-1:0] x, logic [1:0] n);
    logic [OW:0] sum;
    sum = {1'b0, x} + {{(OW-1){1'b0}}, n};
    return sum[OW] ? {OW{1'b1}} : sum[OW-1:0];
  endfunction

  function automatic logic [31:0] to32(logic [OW-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  // acc*10 + d, clamped at the magnitude cap
  function automatic logic [VW-1:0] accumulate(logic [VW-1:0] acc, logic [3:0] d);
    logic [VW+3:0] prod;
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VW{1'b0}}, d};
    return (prod > {4'b0000, MAG_CAP}) ? MAG_CAP : prod[VW-1:0];
  endfunction

  function automatic logic [63:0] int_value(logic [VW-1:0] acc, logic neg);
    logic signed [VW-1:0] r;
    if (neg) begin
      r = signed'({VW{1'b0}} - acc);
    end else begin
      r = acc[VW-1] ? signed'(MAG_MAX) : signed'(acc);
    end
    return 64'(r);
  endfunction

  function automatic scan_t start_num(logic [OW-1:0] st, logic [OW-1:0] sp, logic ng,
                                      logic dt, logic [3:0] d);
    scan_t r;
    r = '0;
    r.mode    = M_NUMBER;
    r.start   = st;
    r.span    = sp;
    r.neg     = ng;
    r.dot     = dt;
    r.stopped = dt;
    r.acc     = dt ? '0 : {{(VW-4){1'b0}}, d};
    return r;
  endfunction

  // Token reported when a pending construct is closed
  function automatic cand_t finish(scan_t f);
    cand_t c;
    c = '0;
    c.t.start  = to32(f.start);
    c.t.length = to32(f.span);
    case (f.mode)
      M_HELD: begin
        c.v        = 1'b1;
        c.t.length = 32'd1;
        c.t.kind   = (f.held == CH_MINUS) ? K_MINUS :
                     (f.held == CH_DOT)   ? K_DOT   : K_UNKNOWN;
      end
      M_IDENT: begin
        c.v      = 1'b1;
        c.t.kind = K_IDENT;
      end
      M_NUMBER: begin
        c.v = 1'b1;
        if (f.dot) begin
          c.t.kind = K_FLOAT;
        end else begin
          c.t.kind  = K_INT;
          c.t.value = int_value(f.acc, f.neg);
        end
      end
      M_STRING, M_BLOCK: begin
        c.v      = 1'b1;
        c.t.kind = K_STRING;
      end
      M_BRACE: begin
        c.v        = 1'b1;
        c.t.kind   = K_STRING;
        c.t.length = to32(sat_add(f.span, 2'd1));
      end
      default: c.v = 1'b0;
    endcase
    return c;
  endfunction

  assign ch         = text.text_byte;
  assign text.ready = !q_full;
  assign accept     = text.valid && text.ready;
  assign zero_byte  = (ch == CH_NUL);
  assign ended      = zero_byte || text.final_byte;

  // Mode update for one byte
  always_comb begin
    s1      = s;
    fin_src = s;
    take_a  = 1'b0;
    idle_go = 1'b0;
    unique case (s.mode)
      M_HELD: begin
        if (s.held == CH_MINUS && is_digit(ch)) begin
          s1 = start_num(s.start, OW'(2), 1'b1, 1'b0, ch[3:0]);
        end else if (s.held == CH_DOT && is_digit(ch)) begin
          s1 = start_num(s.start, OW'(2), 1'b0, 1'b1, ch[3:0]);
        end else if (s.held == CH_SLASH && ch == CH_SLASH) begin
          s1.mode = M_COMMENT;
          s1.held = '0;
        end else if (s.held == CH_AT && ch == CH_LBRACE) begin
          s1.mode  = M_BLOCK;
          s1.held  = '0;
          s1.start = sat_add(pos, 2'd1);
          s1.span  = '0;
        end else begin
          take_a  = 1'b1;
          s1.mode = M_IDLE;
          s1.held = '0;
          idle_go = 1'b1;
        end
      end
      M_COMMENT: begin
        if (ch == CH_LF) begin
          s1.mode = M_IDLE;
          idle_go = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_letter(ch) || is_digit(ch) || ch == CH_UNDERSCORE) begin
          s1.span = sat_add(s.span, 2'd1);
        end else begin
          take_a  = 1'b1;
          s1.mode = M_IDLE;
          idle_go = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(ch)) begin
          s1.span = sat_add(s.span, 2'd1);
          if (!s.stopped) s1.acc = accumulate(s.acc, ch[3:0]);
        end else if (ch == CH_MINUS || ch == CH_DOT) begin
          s1.span    = sat_add(s.span, 2'd1);
          s1.stopped = 1'b1;
          if (ch == CH_DOT) s1.dot = 1'b1;
        end else if (ch == CH_LOWER_F) begin
          // trailing 'f' belongs to the number and closes it
          s1.span = sat_add(s.span, 2'd1);
          fin_src = s1;
          take_a  = 1'b1;
          s1.mode = M_IDLE;
        end else begin
          take_a  = 1'b1;
          s1.mode = M_IDLE;
          idle_go = 1'b1;
        end
      end
      M_STRING: begin
        if (ch == CH_QUOTE) begin
          take_a  = 1'b1;
          s1.mode = M_IDLE;
        end else begin
          s1.span = sat_add(s.span, 2'd1);
        end
      end
      M_BLOCK: begin
        if (ch == CH_RBRACE) begin
          s1.mode = M_BRACE;
        end else begin
          s1.span = sat_add(s.span, 2'd1);
        end
      end
      M_BRACE: begin
        if (ch == CH_AT) begin
          take_a       = 1'b1;
          fin_src.mode = M_BLOCK;
          s1.mode      = M_IDLE;
        end else if (ch == CH_RBRACE) begin
          s1.span = sat_add(s.span, 2'd1);
        end else begin
          s1.span = sat_add(s.span, 2'd2);
          s1.mode = M_BLOCK;
        end
      end
      default: idle_go = 1'b1;
    endcase

    // Byte seen between tokens
    cand_b          = '0;
    cand_b.t.start  = to32(pos);
    cand_b.t.length = 32'd1;
    if (idle_go) begin
      unique case (ch) inside
        CH_SPACE, CH_TAB: ;
        CH_CR, CH_LF: begin
          cand_b.v = 1'b1; cand_b.t.kind = K_NEWLINE;
        end
        CH_COLON:    begin cand_b.v = 1'b1; cand_b.t.kind = K_COLON;    end
        CH_SEMI:     begin cand_b.v = 1'b1; cand_b.t.kind = K_SEMI;     end
        CH_COMMA:    begin cand_b.v = 1'b1; cand_b.t.kind = K_COMMA;    end
        CH_EQUAL:    begin cand_b.v = 1'b1; cand_b.t.kind = K_EQUAL;    end
        CH_STAR:     begin cand_b.v = 1'b1; cand_b.t.kind = K_STAR;     end
        CH_LBRACE:   begin cand_b.v = 1'b1; cand_b.t.kind = K_LBRACE;   end
        CH_RBRACE:   begin cand_b.v = 1'b1; cand_b.t.kind = K_RBRACE;   end
        CH_LBRACKET: begin cand_b.v = 1'b1; cand_b.t.kind = K_LBRACKET; end
        CH_RBRACKET: begin cand_b.v = 1'b1; cand_b.t.kind = K_RBRACKET; end
        CH_LPAREN:   begin cand_b.v = 1'b1; cand_b.t.kind = K_LPAREN;   end
        CH_RPAREN:   begin cand_b.v = 1'b1; cand_b.t.kind = K_RPAREN;   end
        CH_MINUS, CH_DOT, CH_SLASH, CH_AT: begin
          s1.mode  = M_HELD;
          s1.held  = ch;
          s1.start = pos;
        end
        CH_QUOTE: begin
          s1.mode  = M_STRING;
          s1.start = sat_add(pos, 2'd1);
          s1.span  = '0;
        end
        [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]: begin
          s1.mode  = M_IDENT;
          s1.start = pos;
          s1.span  = OW'(1);
        end
        [CH_DIGIT_0:CH_DIGIT_9]: begin
          s1 = start_num(pos, OW'(1), 1'b0, 1'b0, ch[3:0]);
        end
        default: begin
          cand_b.v = 1'b1; cand_b.t.kind = K_UNKNOWN;
        end
      endcase
    end
  end

  // Collect up to two tokens in order and number them
  always_comb begin
    fin_a    = finish(zero_byte ? s : fin_src);
    cand_a   = fin_a;
    cand_a.v = fin_a.v && (zero_byte || take_a);
    fin_c    = finish(s1);
    cand_c   = fin_c;
    cand_c.v = fin_c.v && !zero_byte && text.final_byte;

    slot0 = cand_a.v ? cand_a : ((cand_b.v && !zero_byte) ? cand_b : cand_c);
    if (cand_a.v) begin
      slot1 = (cand_b.v && !zero_byte) ? cand_b : cand_c;
    end else if (cand_b.v && !zero_byte) begin
      slot1 = cand_c;
    end else begin
      slot1 = '0;
    end

    push_data              = '0;
    push_data.two          = slot1.v;
    push_data.t0           = slot0.t;
    push_data.t0.number    = count;
    push_data.t0.run_last  = !slot1.v;
    push_data.t0.stream_end = ended && !slot1.v;
    push_data.t1           = slot1.t;
    push_data.t1.number    = count + 32'd1;
    push_data.t1.run_last  = 1'b1;
    push_data.t1.stream_end = ended;

    push = accept && slot0.v;

    if (ended) begin
      s_next     = '0;
      pos_next   = '0;
      count_next = '0;
    end else begin
      s_next     = s1;
      pos_next   = sat_add(pos, 2'd1);
      count_next = count + 32'(slot0.v) + 32'(slot1.v);
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      s     <= '0;
      pos   <= '0;
      count <= '0;
    end else if (accept) begin
      s     <= s_next;
      pos   <= pos_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

>>> src/ctt_queue.sv
`default_nettype none
module ctt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ctt_pkg::pair_t push_data,
  output logic           full,
  input  logic           pop,
  output ctt_pkg::pair_t pop_data,
  output logic           empty
);
  import ctt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pair_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full     = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ctt_emit.sv
`default_nettype none
module ctt_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  ctt_pkg::pair_t q_data,
  output logic           q_pop,
  ctt_out_if.source      tokens
);
  import ctt_pkg::*;

  pair_t cur;
  logic  cur_valid, second, take, advance;
  tok_t  sel;

  assign take    = tokens.valid && tokens.ready;
  // current entry is used up (or absent) so the next one may load
  assign advance = !cur_valid || (take && (second || !cur.two));
  assign q_pop   = advance && !q_empty;
  assign sel     = second ? cur.t1 : cur.t0;

  assign tokens.valid         = cur_valid;
  assign tokens.token_kind    = sel.kind;
  assign tokens.token_start   = sel.start;
  assign tokens.token_length  = sel.length;
  assign tokens.integer_value = signed'(sel.value);
  assign tokens.token_number  = sel.number;
  assign tokens.run_last      = sel.run_last;
  assign tokens.stream_end    = sel.stream_end;

  // Output register, one token per cycle while tokens.ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (advance) begin
      cur_valid <= !q_empty;
      second    <= 1'b0;
    end else if (take) begin
      second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) cur <= q_data;
  end

endmodule
`default_nettype wire

>>> src/config_text_tokenizer_unit.sv
`default_nettype none
// Streaming tokenizer for a small configuration language. The text port takes one source byte
// per cycle whenever the four-entry token queue has room; the scanner decides each byte's
// tokens (at most two) in that same cycle, with one shift-add multiply-by-ten step for integer
// values. The token port delivers one token per cycle from an output register while the sink
// is ready; a byte that closes one token and opens another (an identifier ended by ':' for
// example) has its two tokens delivered in turn, and the queue absorbs such bursts. A NUL byte
// or final_byte ends the stream, flushes any open token and restarts offsets and token
// numbering at zero. Offsets and lengths saturate at OFFSET_WIDTH bits; integers saturate at
// VALUE_WIDTH signed limits.
module config_text_tokenizer_unit #(
  parameter int OFFSET_WIDTH = 32,
  parameter int VALUE_WIDTH  = 64
) (
  input  logic      clk,
  input  logic      rst,
  ctt_in_if.sink    text,
  ctt_out_if.source tokens
);
  import ctt_pkg::*;

  logic  push, q_full, q_pop, q_empty;
  pair_t push_data, q_data;

  // Front: byte classification and token assembly
  ctt_scan #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  ctt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Back: token delivery
  ctt_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .tokens  (tokens)
  );

endmodule
`default_nettype wire
